FILE: rtl/core/iia_pkg.sv
package iia_pkg;

  // Command codes carried in the command field of an input word.
  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_SUB   = 3'd1;
  localparam logic [2:0] CMD_MUL   = 3'd2;
  localparam logic [2:0] CMD_DIV   = 3'd3;
  localparam logic [2:0] CMD_MOD   = 3'd4;
  localparam logic [2:0] CMD_NEG   = 3'd5;
  localparam logic [2:0] CMD_IDENT = 3'd6;

  // Every query is split into this many corner words.
  localparam int unsigned CORNERS = 4;

  // What the cell chain does with a word.
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  // Control that travels with each corner word down the chain.
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  idx;
    logic        neg;
    logic        ok;
    logic        applied;
  } ctl_t;

  typedef struct packed {
    logic [2:0]         command;
    logic               left_known;
    logic signed [63:0] left_min;
    logic signed [63:0] left_max;
    logic               right_known;
    logic signed [63:0] right_min;
    logic signed [63:0] right_max;
  } in_t;

  typedef struct packed {
    logic               applied;
    logic               result_known;
    logic signed [63:0] result_min;
    logic signed [63:0] result_max;
  } out_t;

endpackage

FILE: rtl/core/int64_interval_arithmetic.sv
// Path: feeder, W chain cells, fold register, output register, then out_o.
//   The feeder takes the next word as the last corner of the current one goes in.
// Rate: each query feeds its four corner words into the cell chain one per
//   cycle unless the datapath is held, so the chain entry sets the rate.
// Reset: rst_ni is asynchronous and active low; it empties the feeder, the
//   chain and the output register. No clearing pass is needed.
module int64_interval_arithmetic #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          stall_o,
  input  iia_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          stall_i,
  output iia_pkg::out_t out_o
);

  localparam int unsigned W = VALUE_WIDTH;
  localparam logic [1:0] LastIdx = 2'(iia_pkg::CORNERS - 1);
  localparam logic [W-1:0] VMin = {1'b1, {(W-1){1'b0}}};

  // Magnitude of a two's complement value; the most negative value maps to
  // 2^(W-1), which still fits the unsigned word.
  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? W'(~x + 1'b1) : x;
  endfunction

  // The whole datapath moves in lock step. It only holds still when a
  // finished word sits in the output register and the consumer stalls.
  logic adv;
  logic accept;

  // Feeder: holds the accepted query while its four corner words go out.
  logic         busy_q;
  logic         busy_d;
  logic [1:0]   cnt_q;
  logic [1:0]   cnt_d;
  iia_pkg::in_t item_q;

  assign adv     = !out_valid_o || !stall_i;
  assign stall_o = busy_q && !(adv && (cnt_q == LastIdx));
  assign accept  = in_valid_i && !stall_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (adv && busy_q) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == LastIdx) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i;
    end
  end

  // Operand set-up. Interval ends are taken from their low W bits. The
  // element-wise operations (add, subtract, negate, identity, modulo) are
  // settled here and ride the chain untouched; multiply and divide send the
  // magnitudes of one corner per cycle into the chain while it is not held.
  logic signed [W-1:0] lmin;
  logic signed [W-1:0] lmax;
  logic signed [W-1:0] rmin;
  logic signed [W-1:0] rmax;
  logic signed [W-1:0] cl;
  logic signed [W-1:0] cr;
  logic signed [W:0]   sa_lo;
  logic signed [W:0]   sb_lo;
  logic signed [W:0]   sa_hi;
  logic signed [W:0]   sb_hi;
  logic signed [W:0]   s_lo;
  logic signed [W:0]   s_hi;
  logic                use_sub;
  logic                unary;
  logic                applied;
  logic                zspan;
  logic                min_neg1;
  logic [W-1:0]        rmag_min;
  logic [W-1:0]        rmag_max;
  logic [W-1:0]        bound;
  logic [W-1:0]        neg_bound;
  logic [W-1:0]        fast_lo;
  logic [W-1:0]        fast_hi;
  logic                fast_ok;
  iia_pkg::ctl_t       ctl0;
  logic [W-1:0]        a0;
  logic [W-1:0]        b0;
  logic [2*W-1:0]      acc0;

  always_comb begin
    lmin  = item_q.left_min[W-1:0];
    lmax  = item_q.left_max[W-1:0];
    rmin  = item_q.right_min[W-1:0];
    rmax  = item_q.right_max[W-1:0];
    cl    = cnt_q[1] ? lmax : lmin;
    cr    = cnt_q[0] ? rmax : rmin;
    unary = (item_q.command == iia_pkg::CMD_NEG) ||
            (item_q.command == iia_pkg::CMD_IDENT);
    applied = (item_q.command <= iia_pkg::CMD_IDENT) && item_q.left_known &&
              (unary || item_q.right_known);

    // A divisor interval that reaches from at most zero to at least zero.
    zspan    = (rmin[W-1] || (rmin == '0)) && !rmax[W-1];
    min_neg1 = (lmin == VMin) && rmin[W-1] && (!rmax[W-1] || (rmax == '1));

    // Add, subtract and negate share one pair of W+1 bit adders.
    sa_lo   = (W+1)'(lmin);
    sb_lo   = (W+1)'(rmin);
    sa_hi   = (W+1)'(lmax);
    sb_hi   = (W+1)'(rmax);
    use_sub = 1'b0;
    if (item_q.command == iia_pkg::CMD_SUB) begin
      sb_lo   = (W+1)'(rmax);
      sb_hi   = (W+1)'(rmin);
      use_sub = 1'b1;
    end else if (item_q.command == iia_pkg::CMD_NEG) begin
      sa_lo   = '0;
      sb_lo   = (W+1)'(lmax);
      sa_hi   = '0;
      sb_hi   = (W+1)'(lmin);
      use_sub = 1'b1;
    end
    s_lo = use_sub ? sa_lo - sb_lo : sa_lo + sb_lo;
    s_hi = use_sub ? sa_hi - sb_hi : sa_hi + sb_hi;

    // The remainder bound is max|divisor| - 1; for a magnitude of 2^(W-1)
    // that already equals the largest positive value.
    rmag_min  = mag(rmin);
    rmag_max  = mag(rmax);
    bound     = ((rmag_min > rmag_max) ? rmag_min : rmag_max) - 1'b1;
    neg_bound = W'(~bound + 1'b1);

    fast_lo = lmin;
    fast_hi = lmax;
    fast_ok = 1'b1;
    unique case (item_q.command)
      iia_pkg::CMD_ADD, iia_pkg::CMD_SUB, iia_pkg::CMD_NEG: begin
        fast_lo = s_lo[W-1:0];
        fast_hi = s_hi[W-1:0];
        fast_ok = (s_lo[W] == s_lo[W-1]) && (s_hi[W] == s_hi[W-1]);
      end
      iia_pkg::CMD_MOD: begin
        fast_ok = !zspan && !min_neg1;
        if (!lmin[W-1]) begin
          fast_lo = '0;
          fast_hi = bound;
        end else if (lmax[W-1] || (lmax == '0)) begin
          fast_lo = neg_bound;
          fast_hi = '0;
        end else begin
          fast_lo = neg_bound;
          fast_hi = bound;
        end
      end
      default: begin
        fast_ok = 1'b1;
      end
    endcase

    ctl0.idx     = cnt_q;
    ctl0.neg     = cl[W-1] ^ cr[W-1];
    ctl0.applied = applied;
    a0           = '0;
    b0           = '0;
    acc0         = {fast_lo, fast_hi};
    if (applied && (item_q.command == iia_pkg::CMD_MUL)) begin
      ctl0.kind = iia_pkg::KIND_MUL;
      ctl0.ok   = 1'b1;
      a0        = mag(cl);
      b0        = mag(cr);
      acc0      = '0;
    end else if (applied && (item_q.command == iia_pkg::CMD_DIV)) begin
      // A reversed divisor interval can still put a zero on one corner.
      ctl0.kind = iia_pkg::KIND_DIV;
      ctl0.ok   = !zspan && (cr != '0) && !((cl == VMin) && (cr == '1));
      a0        = mag(cr);
      acc0      = {{W{1'b0}}, mag(cl)};
    end else begin
      ctl0.kind = iia_pkg::KIND_PASS;
      ctl0.ok   = applied && fast_ok;
    end
  end

  // The cell chain: W identical cells, each working one bit of a product
  // or one quotient bit of a division for the corner word it holds.
  logic            ch_valid [W+1];
  iia_pkg::ctl_t   ch_ctl   [W+1];
  logic [W-1:0]    ch_a     [W+1];
  logic [W-1:0]    ch_b     [W+1];
  logic [2*W-1:0]  ch_acc   [W+1];

  assign ch_valid[0] = busy_q;
  assign ch_ctl[0]   = ctl0;
  assign ch_a[0]     = a0;
  assign ch_b[0]     = b0;
  assign ch_acc[0]   = acc0;

  for (genvar g = 0; g < W; g++) begin : g_cell
    iia_cell #(
      .Width(W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (ch_valid[g]),
      .ctl_i   (ch_ctl[g]),
      .a_i     (ch_a[g]),
      .b_i     (ch_b[g]),
      .acc_i   (ch_acc[g]),
      .valid_o (ch_valid[g+1]),
      .ctl_o   (ch_ctl[g+1]),
      .a_o     (ch_a[g+1]),
      .b_o     (ch_b[g+1]),
      .acc_o   (ch_acc[g+1])
    );
  end

  // Sign fix-up, overflow check, corner min/max and the output register.
  iia_fold #(
    .Width(W)
  ) u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (ch_valid[W]),
    .ctl_i       (ch_ctl[W]),
    .acc_i       (ch_acc[W]),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  // An operation that was not applied can never report a known result.
  a_known_needs_applied : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.applied |-> !out_o.result_known)
    else $error("result known without an applied operation");

  // A failed or skipped operation reports a zero interval.
  a_unknown_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.result_known |->
      (out_o.result_min == '0) && (out_o.result_max == '0))
    else $error("unknown result carries nonzero ends");

  // While the datapath is held, the feeder must not skip a corner.
  a_corner_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !adv |=> $stable(cnt_q) && busy_q)
    else $error("corner counter moved while the datapath was held");

  // An empty feeder always takes a word.
  a_idle_takes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !stall_o)
    else $error("input stalled with an empty feeder");

endmodule

FILE: rtl/core/iia_cell.sv
module iia_cell #(
  parameter int unsigned Width = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  iia_pkg::ctl_t        ctl_i,
  input  logic [Width-1:0]     a_i,
  input  logic [Width-1:0]     b_i,
  input  logic [2*Width-1:0]   acc_i,
  output logic                 valid_o,
  output iia_pkg::ctl_t        ctl_o,
  output logic [Width-1:0]     a_o,
  output logic [Width-1:0]     b_o,
  output logic [2*Width-1:0]   acc_o
);

  logic                 valid_q;
  iia_pkg::ctl_t        ctl_q;
  logic [Width-1:0]     a_q;
  logic [Width-1:0]     b_q;
  logic [Width-1:0]     b_d;
  logic [2*Width-1:0]   acc_q;
  logic [2*Width-1:0]   acc_d;
  logic [2*Width:0]     msum;
  logic [2*Width:0]     dsh;
  logic [Width:0]       drem;
  logic                 dq;

  // One multiplier bit (shift-add, product settles in acc) or one restoring
  // division step (remainder in the upper half, quotient in the lower half).
  always_comb begin
    msum  = {1'b0, acc_i} + (b_i[0] ? {1'b0, a_i, {Width{1'b0}}} : '0);
    dsh   = {acc_i, 1'b0};
    dq    = dsh[2*Width:Width] >= {1'b0, a_i};
    drem  = dq ? dsh[2*Width:Width] - {1'b0, a_i} : dsh[2*Width:Width];
    acc_d = acc_i;
    b_d   = b_i;
    unique case (ctl_i.kind)
      iia_pkg::KIND_MUL: begin
        acc_d = msum[2*Width:1];
        b_d   = b_i >> 1;
      end
      iia_pkg::KIND_DIV: begin
        acc_d = {drem[Width-1:0], dsh[Width-1:1], dq};
      end
      default: begin
        acc_d = acc_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q <= ctl_i;
      a_q   <= a_i;
      b_q   <= b_d;
      acc_q <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign acc_o   = acc_q;

endmodule

FILE: rtl/core/iia_fold.sv
module iia_fold #(
  parameter int unsigned Width = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  iia_pkg::ctl_t        ctl_i,
  input  logic [2*Width-1:0]   acc_i,
  output logic                 out_valid_o,
  output iia_pkg::out_t        out_o
);

  localparam logic [Width-1:0] Half = {1'b1, {(Width-1){1'b0}}};
  localparam logic [1:0]       LastIdx = 2'(iia_pkg::CORNERS - 1);

  logic [Width-1:0]        lo;
  logic                    negr;
  logic                    ovf;
  logic [2*Width-1:0]      f_val_d;
  logic                    f_ok_d;

  logic                    f_valid_q;
  iia_pkg::ctl_t           f_ctl_q;
  logic [2*Width-1:0]      f_val_q;
  logic                    f_ok_q;

  logic signed [Width-1:0] v;
  logic signed [Width-1:0] pmn;
  logic signed [Width-1:0] mn_d;
  logic signed [Width-1:0] mn_q;
  logic signed [Width-1:0] mx_d;
  logic signed [Width-1:0] mx_q;
  logic                    ok_d;
  logic                    ok_q;
  logic                    is_pass;

  logic                    out_valid_q;
  iia_pkg::out_t           out_q;

  // Turn the unsigned magnitude from the chain back into a signed corner.
  always_comb begin
    lo      = acc_i[Width-1:0];
    negr    = ctl_i.neg && (lo != '0);
    ovf     = 1'b0;
    f_val_d = acc_i;
    f_ok_d  = ctl_i.ok;
    unique case (ctl_i.kind)
      iia_pkg::KIND_MUL: begin
        ovf     = (acc_i[2*Width-1:Width] != '0) || (!negr && lo[Width-1]) ||
                  (negr && (lo > Half));
        f_ok_d  = ctl_i.ok && !ovf;
        f_val_d = {{Width{1'b0}}, (negr ? Width'(~lo + 1'b1) : lo)};
      end
      iia_pkg::KIND_DIV: begin
        f_val_d = {{Width{1'b0}}, (ctl_i.neg ? Width'(~lo + 1'b1) : lo)};
      end
      default: begin
        f_val_d = acc_i;
      end
    endcase
  end

  // Running minimum and maximum over the four corners of one query.
  always_comb begin
    v       = f_val_q[Width-1:0];
    pmn     = f_val_q[2*Width-1:Width];
    is_pass = (f_ctl_q.kind == iia_pkg::KIND_PASS);
    if (f_ctl_q.idx == '0) begin
      mn_d = is_pass ? pmn : v;
      mx_d = v;
      ok_d = f_ok_q;
    end else begin
      mn_d = (!is_pass && (v < mn_q)) ? v : mn_q;
      mx_d = (!is_pass && (v > mx_q)) ? v : mx_q;
      ok_d = ok_q && f_ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      f_valid_q   <= valid_i;
      out_valid_q <= f_valid_q && (f_ctl_q.idx == LastIdx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f_ctl_q <= ctl_i;
      f_val_q <= f_val_d;
      f_ok_q  <= f_ok_d;
      if (f_valid_q) begin
        mn_q <= mn_d;
        mx_q <= mx_d;
        ok_q <= ok_d;
      end
      out_q.applied      <= f_ctl_q.applied;
      out_q.result_known <= ok_d;
      out_q.result_min   <= ok_d ? 64'(mn_d) : '0;
      out_q.result_max   <= ok_d ? 64'(mx_d) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Command code that names no operation.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam longint VAL_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint VAL_MIN = 64'sh8000_0000_0000_0000;
  localparam int RANDOM_WORDS = 382;
  // Long hold-off of the result channel, so that the unit fills up.
  localparam int HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic stall_o;
  iia_pkg::in_t in_i = '0;
  logic out_valid_o;
  logic stall_i = 1'b0;
  iia_pkg::out_t out_o;

  // Query words waiting to be offered, and results still owed by the unit.
  iia_pkg::in_t  query_q[$];
  iia_pkg::out_t expect_q[$];
  iia_pkg::out_t exp_word;
  int total_words = 0;
  int checked_cnt = 0;
  int error_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  always #4 clk_i = ~clk_i;

  int64_interval_arithmetic uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stall_o    (stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .stall_i    (stall_i),
    .out_o      (out_o)
  );

  // Predictor helpers, all on full 64-bit values.
  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit add_chk(input longint a, input longint b, output longint r);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    r = s[63:0];
    return s[64] == s[63];
  endfunction

  function automatic bit sub_chk(input longint a, input longint b, output longint r);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    r = s[63:0];
    return s[64] == s[63];
  endfunction

  function automatic bit mul_chk(input longint a, input longint b, output longint r);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    r = p[63:0];
    return (p[127:63] == '0) || (p[127:63] == '1);
  endfunction

  function automatic bit div_chk(input longint a, input longint b, output longint r);
    r = 0;
    if ((b == 0) || ((a == VAL_MIN) && (b == -1))) begin
      return 1'b0;
    end
    r = a / b;
    return 1'b1;
  endfunction

  function automatic iia_pkg::out_t predict(input iia_pkg::in_t q);
    iia_pkg::out_t r;
    longint lmin;
    longint lmax;
    longint rmin;
    longint rmax;
    longint omin;
    longint omax;
    longint v [4];
    bit unary;
    bit applied;
    bit ok;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] big;
    logic [63:0] bound;
    lmin = q.left_min;
    lmax = q.left_max;
    rmin = q.right_min;
    rmax = q.right_max;
    omin = 0;
    omax = 0;
    ok = 1'b0;
    unary = (q.command == iia_pkg::CMD_NEG) || (q.command == iia_pkg::CMD_IDENT);
    applied = (q.command <= iia_pkg::CMD_IDENT) && q.left_known &&
              (unary || q.right_known);
    if (applied) begin
      unique case (q.command)
        iia_pkg::CMD_ADD: begin
          ok = add_chk(lmin, rmin, omin) && add_chk(lmax, rmax, omax);
        end
        iia_pkg::CMD_SUB: begin
          ok = sub_chk(lmin, rmax, omin) && sub_chk(lmax, rmin, omax);
        end
        iia_pkg::CMD_MUL: begin
          ok = mul_chk(lmin, rmin, v[0]) && mul_chk(lmin, rmax, v[1]) &&
               mul_chk(lmax, rmin, v[2]) && mul_chk(lmax, rmax, v[3]);
        end
        iia_pkg::CMD_DIV: begin
          if ((rmin <= 0) && (rmax >= 0)) begin
            ok = 1'b0;
          end else begin
            ok = div_chk(lmin, rmin, v[0]) && div_chk(lmin, rmax, v[1]) &&
                 div_chk(lmax, rmin, v[2]) && div_chk(lmax, rmax, v[3]);
          end
        end
        iia_pkg::CMD_MOD: begin
          if ((rmin <= 0) && (rmax >= 0)) begin
            ok = 1'b0;
          end else if ((lmin <= VAL_MIN) && (lmax >= VAL_MIN) && (rmin <= -1) &&
                       (rmax >= -1)) begin
            ok = 1'b0;
          end else begin
            ma  = magnitude(rmin);
            mb  = magnitude(rmax);
            big = (ma > mb) ? ma : mb;
            if (big == 64'd0) begin
              ok = 1'b0;
            end else begin
              bound = (big > 64'(VAL_MAX)) ? 64'(VAL_MAX) : big - 64'd1;
              if (lmin >= 0) begin
                omin = 0;
                omax = $signed(bound);
              end else if (lmax <= 0) begin
                omin = -$signed(bound);
                omax = 0;
              end else begin
                omin = -$signed(bound);
                omax = $signed(bound);
              end
              ok = 1'b1;
            end
          end
        end
        iia_pkg::CMD_NEG: begin
          ok = sub_chk(0, lmax, omin) && sub_chk(0, lmin, omax);
        end
        default: begin
          omin = lmin;
          omax = lmax;
          ok = 1'b1;
        end
      endcase
      if (ok && ((q.command == iia_pkg::CMD_MUL) || (q.command == iia_pkg::CMD_DIV))) begin
        omin = v[0];
        omax = v[0];
        for (int i = 1; i < 4; i++) begin
          if (v[i] < omin) begin
            omin = v[i];
          end
          if (v[i] > omax) begin
            omax = v[i];
          end
        end
      end
    end
    if (!ok) begin
      omin = 0;
      omax = 0;
    end
    r.applied      = applied;
    r.result_known = ok;
    r.result_min   = omin;
    r.result_max   = omax;
    return r;
  endfunction

  // Values biased toward the edges of the range and toward small numbers.
  function automatic longint pick_value();
    int sel;
    longint x;
    sel = $urandom_range(9);
    case (sel)
      0: x = VAL_MIN;
      1: x = VAL_MAX;
      2: x = 0;
      3: x = -1;
      4: x = 1;
      5: x = longint'($urandom_range(200)) - 100;
      6: x = longint'($signed($urandom));
      7: x = longint'($signed(16'($urandom)));
      default: x = {$urandom, $urandom};
    endcase
    return x;
  endfunction

  function automatic iia_pkg::in_t make_query(input logic [2:0] cmd);
    iia_pkg::in_t q;
    longint x;
    longint y;
    q.command     = cmd;
    q.left_known  = ($urandom_range(15) != 0);
    q.right_known = ($urandom_range(15) != 0);
    x = pick_value();
    y = pick_value();
    if ((x > y) && ($urandom_range(7) != 0)) begin
      q.left_min = y;
      q.left_max = x;
    end else begin
      q.left_min = x;
      q.left_max = y;
    end
    x = pick_value();
    y = pick_value();
    if ((x > y) && ($urandom_range(7) != 0)) begin
      q.right_min = y;
      q.right_max = x;
    end else begin
      q.right_min = x;
      q.right_max = y;
    end
    return q;
  endfunction

  function automatic iia_pkg::in_t make_fixed(input logic [2:0] cmd, input logic lk,
                                              input longint lmin, input longint lmax,
                                              input logic rk, input longint rmin,
                                              input longint rmax);
    iia_pkg::in_t q;
    q.command     = cmd;
    q.left_known  = lk;
    q.left_min    = lmin;
    q.left_max    = lmax;
    q.right_known = rk;
    q.right_min   = rmin;
    q.right_max   = rmax;
    return q;
  endfunction

  // Driver: a word stays on the bus until it is taken; its expected result
  // is queued at the edge that accepts it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !stall_o) begin
      if (in_valid_i) begin
        expect_q.push_back(predict(in_i));
      end
      if ((query_q.size() != 0) && (int'($urandom_range(99)) >= idle_pct)) begin
        in_i       <= query_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long hold-off of the result channel, counted here.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks every result word taken and drives the stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !stall_i) begin
        checked_cnt = checked_cnt + 1;
        if (expect_q.size() == 0) begin
          error_cnt = error_cnt + 1;
          $display("%0t: expected no word, got applied=%0d known=%0d min=%0d max=%0d",
                   $time, out_o.applied, out_o.result_known, out_o.result_min,
                   out_o.result_max);
        end else begin
          exp_word = expect_q.pop_front();
          if (out_o !== exp_word) begin
            error_cnt = error_cnt + 1;
            $display("%0t: expected applied=%0d known=%0d min=%0d max=%0d, got applied=%0d known=%0d min=%0d max=%0d",
                     $time, exp_word.applied, exp_word.result_known,
                     exp_word.result_min, exp_word.result_max, out_o.applied,
                     out_o.result_known, out_o.result_min, out_o.result_max);
          end
        end
      end
      stall_i <= (hold_left != 0) || (int'($urandom_range(99)) < stall_pct);
    end
  end

  initial begin
    // Edge cases first, then random words.
    query_q.push_back(make_fixed(iia_pkg::CMD_ADD, 1'b1, 0, VAL_MAX, 1'b1, 0, 1));
    query_q.push_back(make_fixed(iia_pkg::CMD_ADD, 1'b1, -5, 5, 1'b1, 10, 20));
    query_q.push_back(make_fixed(iia_pkg::CMD_SUB, 1'b1, VAL_MIN, 0, 1'b1, 1, 1));
    query_q.push_back(make_fixed(iia_pkg::CMD_MUL, 1'b1, VAL_MIN, VAL_MIN, 1'b1, 1, 1));
    query_q.push_back(make_fixed(iia_pkg::CMD_MUL, 1'b1, VAL_MIN, 0, 1'b1, -1, 1));
    query_q.push_back(make_fixed(iia_pkg::CMD_MUL, 1'b1, 64'sh1_0000_0000,
                                 64'sh1_0000_0000, 1'b1, 64'sh8000_0000,
                                 64'sh8000_0000));
    query_q.push_back(make_fixed(iia_pkg::CMD_MUL, 1'b1, -64'sh1_0000_0000,
                                 -64'sh1_0000_0000, 1'b1, 64'sh8000_0000,
                                 64'sh8000_0000));
    query_q.push_back(make_fixed(iia_pkg::CMD_DIV, 1'b1, 10, 100, 1'b1, -3, 4));
    query_q.push_back(make_fixed(iia_pkg::CMD_DIV, 1'b1, 10, 100, 1'b1, 5, 0));
    query_q.push_back(make_fixed(iia_pkg::CMD_DIV, 1'b1, VAL_MIN, 5, 1'b1, -4, -1));
    query_q.push_back(make_fixed(iia_pkg::CMD_DIV, 1'b1, -100, 77, 1'b1, 3, 7));
    query_q.push_back(make_fixed(iia_pkg::CMD_MOD, 1'b1, VAL_MIN, 0, 1'b1, -3, -1));
    query_q.push_back(make_fixed(iia_pkg::CMD_MOD, 1'b1, -5, 5, 1'b1, VAL_MIN, -1));
    query_q.push_back(make_fixed(iia_pkg::CMD_MOD, 1'b1, 3, 9, 1'b1, 5, 0));
    query_q.push_back(make_fixed(iia_pkg::CMD_NEG, 1'b1, VAL_MIN, 3, 1'b0, 0, 0));
    query_q.push_back(make_fixed(iia_pkg::CMD_IDENT, 1'b1, 7, -7, 1'b0, 0, 0));
    query_q.push_back(make_fixed(CMD_UNUSED, 1'b1, 1, 2, 1'b1, 3, 4));
    query_q.push_back(make_fixed(iia_pkg::CMD_ADD, 1'b0, 1, 2, 1'b1, 3, 4));
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      query_q.push_back(make_query(3'($urandom_range(7))));
    end
    total_words = query_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase with no idling, then a long hold-off while words keep coming.
    wait (checked_cnt >= 40);
    hold_go = 1'b1;
    wait (hold_done && (hold_left == 0));
    idle_pct = 56;
    wait (checked_cnt >= 150);
    idle_pct  = 0;
    stall_pct = 56;
    wait (checked_cnt >= 260);
    idle_pct  = 9;
    stall_pct = 9;
    wait (checked_cnt >= total_words);
    repeat (20) @(posedge clk_i);
    if ((error_cnt == 0) && (expect_q.size() == 0) && (checked_cnt == total_words)) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/iia_pkg.sv
rtl/core/iia_cell.sv
rtl/core/iia_fold.sv
rtl/core/int64_interval_arithmetic.sv
dv/testbench.sv
